// ===== rtl/core/ilie_pkg.sv =====
// ---------------------------------------------------------------------------
// Indexed list package
// Request and status codes, and the control word broadcast to the cell row.
// ---------------------------------------------------------------------------
package ilie_pkg;

  // Index and count width inside the cell row; covers every supported depth.
  localparam int IDX_W = 9;

  // Request codes carried on the input tuser.
  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_READ   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  // Status codes returned with every result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control word seen by every cell in the same cycle.
  typedef struct packed {
    logic             do_push;   // write at index cnt
    logic             do_insert; // shift up from pos, write at pos
    logic             do_erase;  // shift down onto pos
    logic [IDX_W-1:0] pos;       // request index
    logic [IDX_W-1:0] cnt;       // item count before the request
    logic [IDX_W-1:0] rd_idx;    // index driven onto the read bus
  } cell_ctrl_t;

endpackage

// ===== rtl/core/indexed_list_insert_erase_unit.sv =====
// Latency: a result item appears on the output in the cycle after its request item is taken.
// Throughput: one item per cycle while m_tready keeps up; all cells update at one edge.
// Insert and erase shift all later entries by one place in that same edge.
// Reset: the item count and the output valid clear; list entries keep whatever they hold.
// ---------------------------------------------------------------------------
// Indexed list insert and erase unit
// An ordered list of up to DEPTH entries held in a row of cells, served by
// push, pop, insert, erase, read and clear requests, one result per request.
// ---------------------------------------------------------------------------
module indexed_list_insert_erase_unit #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // position [4:0], item_value [36:5], zero [39:37]
  input  logic [2:0]  s_tuser,  // req_type [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // item_out [31:0], item_count [37:32], zero [39:38]
  output logic [1:0]  m_tuser   // status [1:0]
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = ilie_pkg::IDX_W;

  logic                 acc;
  ilie_pkg::req_t       req;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        cnt_x;
  logic [WIDTH-1:0]     wr_value;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  ilie_pkg::status_t    status_next;
  logic                 rd_en;
  logic                 full;
  logic                 pos_ok;
  ilie_pkg::cell_ctrl_t ctrl;
  logic [WIDTH-1:0]     rd_bus;
  logic [31:0]          item_next;
  logic [31:0]          item_out;
  logic [5:0]           item_count;
  ilie_pkg::status_t    status;
  logic [WIDTH-1:0]     entry_q [DEPTH];
  logic [WIDTH-1:0]     rd_part [DEPTH];

  // Input handshake: a new item is taken whenever the output register frees.
  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;
  assign req      = ilie_pkg::req_t'(s_tuser);
  assign pos_x    = XW'(s_tdata[4:0]);
  assign cnt_x    = XW'(count);
  assign wr_value = WIDTH'(s_tdata[36:5]);
  assign full     = (count == CNT_W'(DEPTH));
  assign pos_ok   = (pos_x < cnt_x);

  // Request decode: status, new count and the control word for the cells.
  always_comb begin
    status_next    = ilie_pkg::ST_OK;
    count_next     = count;
    rd_en          = 1'b0;
    ctrl           = '0;
    ctrl.pos       = pos_x;
    ctrl.cnt       = cnt_x;
    ctrl.rd_idx    = pos_x;
    case (req)
      ilie_pkg::REQ_PUSH: begin
        if (full) begin
          status_next = ilie_pkg::ST_FULL;
        end else begin
          ctrl.do_push = acc;
          count_next   = count + CNT_W'(1);
        end
      end
      ilie_pkg::REQ_POP: begin
        if (count == '0) begin
          status_next = ilie_pkg::ST_RANGE;
        end else begin
          rd_en       = 1'b1;
          ctrl.rd_idx = cnt_x - XW'(1);
          count_next  = count - CNT_W'(1);
        end
      end
      ilie_pkg::REQ_INSERT: begin
        if (!pos_ok) begin
          status_next = ilie_pkg::ST_RANGE;
        end else if (full) begin
          status_next = ilie_pkg::ST_FULL;
        end else begin
          ctrl.do_insert = acc;
          count_next     = count + CNT_W'(1);
        end
      end
      ilie_pkg::REQ_ERASE: begin
        if (!pos_ok) begin
          status_next = ilie_pkg::ST_RANGE;
        end else begin
          ctrl.do_erase = acc;
          count_next    = count - CNT_W'(1);
        end
      end
      ilie_pkg::REQ_READ: begin
        if (!pos_ok) begin
          status_next = ilie_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      ilie_pkg::REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = ilie_pkg::ST_RANGE;
      end
    endcase
  end

  // Row of cells, each linked to its neighbours; the end cells have only one.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] prev_entry;
    logic [WIDTH-1:0] next_entry;
    if (i == 0) begin : g_first
      assign prev_entry = wr_value;
    end else begin : g_inner_prev
      assign prev_entry = entry_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entry_q[i];
    end else begin : g_inner_next
      assign next_entry = entry_q[i+1];
    end
    ilie_cell #(
      .WIDTH (WIDTH),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_value   (wr_value),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (entry_q[i]),
      .rd_data    (rd_part[i])
    );
  end

  // Read bus: at most one cell drives a non-zero word.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd_part[i];
    end
  end

  assign item_next = rd_en ? 32'(rd_bus) : '0;

  // Item count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc) begin
      count <= count_next;
    end
  end

  // Output register: holds a result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_out   <= item_next;
      item_count <= 6'(count_next);
      status     <= status_next;
    end
  end

  assign m_tdata = {2'b00, item_count, item_out};
  assign m_tuser = status;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("item count above capacity");

  // A push that is not refused grows the list by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    acc && (req == ilie_pkg::REQ_PUSH) && !full |=> count == $past(count) + CNT_W'(1))
    else $error("push did not grow the list");

  // A clear empties the list.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    acc && (req == ilie_pkg::REQ_CLEAR) |=> count == '0)
    else $error("clear did not empty the list");

  // Every accepted item yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> m_tvalid)
    else $error("accepted item gave no result");

endmodule

// ===== rtl/core/ilie_cell.sv =====
// ---------------------------------------------------------------------------
// Indexed list cell
// Holds one list entry and takes its next value from the request value or
// from a neighbouring cell, so that an insert or erase shifts every later entry together.
// ---------------------------------------------------------------------------
module ilie_cell #(
  parameter int WIDTH = 32,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  ilie_pkg::cell_ctrl_t ctrl,
  input  logic [WIDTH-1:0]    wr_value,
  input  logic [WIDTH-1:0]    prev_entry,
  input  logic [WIDTH-1:0]    next_entry,
  output logic [WIDTH-1:0]    entry,
  output logic [WIDTH-1:0]    rd_data
);

  localparam int XW = ilie_pkg::IDX_W;
  localparam logic [XW-1:0] MY_IDX = XW'(IDX);

  logic [WIDTH-1:0] entry_next;

  // Choose the new contents of this place in the list.
  always_comb begin
    entry_next = entry;
    if (ctrl.do_push && (MY_IDX == ctrl.cnt)) begin
      entry_next = wr_value;
    end
    if (ctrl.do_insert) begin
      if (MY_IDX == ctrl.pos) begin
        entry_next = wr_value;
      end else if ((MY_IDX > ctrl.pos) && (MY_IDX <= ctrl.cnt)) begin
        entry_next = prev_entry;
      end
    end
    if (ctrl.do_erase && (MY_IDX >= ctrl.pos) && (MY_IDX < ctrl.cnt - XW'(1))) begin
      entry_next = next_entry;
    end
  end

  // The entry itself has no reset: it is undefined until written.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // Only the addressed cell drives the shared read bus.
  assign rd_data = (MY_IDX == ctrl.rd_idx) ? entry : '0;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Indexed list insert and erase unit testbench
// Sends push, pop, insert, erase, read, clear and unused requests, keeps its
// own copy of the list to work out each response, and checks every response
// item field by field against the oldest expected one. Directed corner cases
// come first, then fill-to-full sequences and random request streams under
// three idling patterns on the two stream interfaces.
// ---------------------------------------------------------------------------
module testbench;

  localparam int LIST_DEPTH = 32;
  localparam int STALL_LIMIT = 2000;

  // Request codes that the block does not define; they must be refused.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    ilie_pkg::status_t status;
    logic [31:0]       item;
    logic [5:0]        count;
  } list_resp_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;  // position [4:0], item_value [36:5], zero [39:37]
  logic [2:0]  s_tuser;  // req_type [2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;  // item_out [31:0], item_count [37:32], zero [39:38]
  logic [1:0]  m_tuser;  // status [1:0]

  // Shadow copy of the list and the responses still owed by the block.
  logic [31:0]  list_mem [LIST_DEPTH];
  int           list_len;
  list_resp_t   resp_q[$];
  int           mismatch_count;
  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;
  int unsigned  stall_cycles;
  list_resp_t   want;

  indexed_list_insert_erase_unit #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(32)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one request to the shadow list and returns the response it owes.
  function automatic list_resp_t apply_list_request(logic [2:0] req, logic [4:0] pos,
                                                    logic [31:0] val);
    list_resp_t r;
    int         i;
    r.status = ilie_pkg::ST_OK;
    r.item   = '0;
    case (req)
      ilie_pkg::REQ_PUSH: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ilie_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      ilie_pkg::REQ_POP: begin
        if (list_len == 0) begin
          r.status = ilie_pkg::ST_RANGE;
        end else begin
          list_len--;
          r.item = list_mem[list_len];
        end
      end
      ilie_pkg::REQ_INSERT: begin
        // The index test comes before the full test.
        if (pos >= list_len) begin
          r.status = ilie_pkg::ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ilie_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      ilie_pkg::REQ_ERASE: begin
        if (pos >= list_len) begin
          r.status = ilie_pkg::ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ilie_pkg::REQ_READ: begin
        if (pos >= list_len) r.status = ilie_pkg::ST_RANGE;
        else r.item = list_mem[pos];
      end
      ilie_pkg::REQ_CLEAR: begin
        // Entries keep their bits; only the count goes back to zero.
        list_len = 0;
      end
      default: begin
        r.status = ilie_pkg::ST_RANGE;
      end
    endcase
    r.count = 6'(list_len);
    return r;
  endfunction

  // Sends one request item, with random idle cycles before it. Called and
  // returns just after a falling edge; tvalid stays high for a following item.
  task automatic send_request(input logic [2:0] req, input logic [4:0] pos,
                              input logic [31:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {3'b000, val, pos};
    s_tuser  = req;
    do @(posedge clk); while (!s_tready);
    resp_q.push_back(apply_list_request(req, pos, val));
    @(negedge clk);
  endtask

  // Holds the sender off until every owed response has come back.
  task automatic wait_for_responses();
    s_tvalid = 1'b0;
    while (resp_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_item_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'h0000_0000;
    if (roll < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Corner cases on an empty and a short list, every request kind and the
  // extremes of each field.
  task automatic test_directed_cases();
    send_request(ilie_pkg::REQ_POP,    5'd0,  32'h0000_0000);  // pop from empty list
    send_request(ilie_pkg::REQ_READ,   5'd0,  32'h0000_0000);  // read on empty list
    send_request(ilie_pkg::REQ_ERASE,  5'd0,  32'h0000_0000);  // erase on empty list
    send_request(ilie_pkg::REQ_INSERT, 5'd0,  32'hDEAD_BEEF);  // insert cannot append
    send_request(REQ_SPARE_A, 5'd31, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_B, 5'd31, 32'hFFFF_FFFF);
    send_request(ilie_pkg::REQ_PUSH,   5'd0,  32'h0000_0000);
    send_request(ilie_pkg::REQ_PUSH,   5'd31, 32'hFFFF_FFFF);
    send_request(ilie_pkg::REQ_PUSH,   5'd0,  32'hA5A5_A5A5);
    send_request(ilie_pkg::REQ_INSERT, 5'd0,  32'h1234_5678);  // insert at the head
    send_request(ilie_pkg::REQ_INSERT, 5'd2,  32'h5A5A_5A5A);  // insert in the middle
    send_request(ilie_pkg::REQ_INSERT, 5'd5,  32'h0F0F_0F0F);  // index equal to count
    send_request(ilie_pkg::REQ_READ,   5'd0,  32'h0000_0000);
    send_request(ilie_pkg::REQ_READ,   5'd2,  32'h0000_0000);
    send_request(ilie_pkg::REQ_READ,   5'd4,  32'h0000_0000);
    send_request(ilie_pkg::REQ_READ,   5'd31, 32'h0000_0000);  // read out of range
    send_request(ilie_pkg::REQ_ERASE,  5'd4,  32'h0000_0000);  // erase the tail
    send_request(ilie_pkg::REQ_ERASE,  5'd0,  32'h0000_0000);  // erase the head
    send_request(ilie_pkg::REQ_READ,   5'd0,  32'h0000_0000);
    send_request(ilie_pkg::REQ_POP,    5'd0,  32'h0000_0000);
    send_request(ilie_pkg::REQ_CLEAR,  5'd0,  32'h0000_0000);
    send_request(ilie_pkg::REQ_POP,    5'd0,  32'h0000_0000);
    send_request(ilie_pkg::REQ_READ,   5'd0,  32'h0000_0000);  // stale entry after clear
    send_request(ilie_pkg::REQ_PUSH,   5'd0,  32'h8000_0001);
    wait_for_responses();
  endtask

  // Fills the list to capacity, probes the full-list refusals, then works on
  // the full list with random content.
  task automatic test_full_list();
    int k;
    send_request(ilie_pkg::REQ_CLEAR, 5'($urandom_range(31)), random_item_value());
    while (list_len < LIST_DEPTH)
      send_request(ilie_pkg::REQ_PUSH, 5'($urandom_range(31)), random_item_value());
    send_request(ilie_pkg::REQ_PUSH,   5'($urandom_range(31)), random_item_value());
    send_request(ilie_pkg::REQ_INSERT, 5'($urandom_range(31)), random_item_value());
    send_request(ilie_pkg::REQ_INSERT, 5'd0, random_item_value());
    send_request(ilie_pkg::REQ_READ,   5'd31, 32'h0000_0000);
    send_request(ilie_pkg::REQ_POP,    5'd0, 32'h0000_0000);
    send_request(ilie_pkg::REQ_INSERT, 5'd0, random_item_value());
    send_request(ilie_pkg::REQ_ERASE,  5'd31, 32'h0000_0000);
    send_request(ilie_pkg::REQ_INSERT, 5'd30, random_item_value());
    for (k = 0; k < 8; k++) begin
      send_request(ilie_pkg::REQ_READ, 5'($urandom_range(31)), 32'h0000_0000);
    end
    send_request(ilie_pkg::REQ_ERASE, 5'($urandom_range(31)), 32'h0000_0000);
  endtask

  // Random request stream, weighted by the current fill level so that the
  // list length wanders over its whole range.
  task automatic test_random_requests(input int n_items);
    int          k;
    int unsigned roll;
    logic [2:0]  req;
    logic [4:0]  pos;
    for (k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        req = ($urandom_range(1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;
      end else if (roll < 4) begin
        req = ilie_pkg::REQ_CLEAR;
      end else begin
        roll = $urandom_range(99);
        if (list_len > 24) begin
          if (roll < 15) req = ilie_pkg::REQ_PUSH;
          else if (roll < 40) req = ilie_pkg::REQ_POP;
          else if (roll < 55) req = ilie_pkg::REQ_INSERT;
          else if (roll < 80) req = ilie_pkg::REQ_ERASE;
          else req = ilie_pkg::REQ_READ;
        end else begin
          if (roll < 30) req = ilie_pkg::REQ_PUSH;
          else if (roll < 42) req = ilie_pkg::REQ_POP;
          else if (roll < 65) req = ilie_pkg::REQ_INSERT;
          else if (roll < 78) req = ilie_pkg::REQ_ERASE;
          else req = ilie_pkg::REQ_READ;
        end
      end
      // Mostly a valid index, sometimes any index.
      if ($urandom_range(99) < 85 && list_len > 0) pos = 5'($urandom_range(list_len - 1));
      else pos = 5'($urandom_range(31));
      send_request(req, pos, random_item_value());
      if ($urandom_range(99) < 2) wait_for_responses();
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_idle_pct);
  end

  // Response checking against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, got status %0d item %h count %0d",
                 $time, m_tuser, m_tdata[31:0], m_tdata[37:32]);
        mismatch_count++;
      end else begin
        want = resp_q.pop_front();
        if (m_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[31:0] !== want.item) begin
          $display("%0t: item_out mismatch, expected %h, got %h", $time, want.item,
                   m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tdata[37:32] !== want.count) begin
          $display("%0t: item_count mismatch, expected %0d, got %0d", $time, want.count,
                   m_tdata[37:32]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    mismatch_count = 0;
    list_len       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Slow receiver.
    src_idle_pct  = 15;
    sink_idle_pct = 87;
    test_directed_cases();
    test_full_list();
    test_random_requests(90);
    wait_for_responses();

    // Slow sender.
    src_idle_pct  = 87;
    sink_idle_pct = 15;
    test_full_list();
    test_random_requests(90);
    wait_for_responses();

    // Full rate on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_requests(96);
    wait_for_responses();

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && resp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ilie_pkg.sv
rtl/core/ilie_cell.sv
rtl/core/indexed_list_insert_erase_unit.sv
bench/testbench.sv
